// ===== rtl/qmn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_pkg
// Widths, constants and types shared by the normalized quaternion product.
// ----------------------------------------------------------------------------
package qmn_pkg;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam int NC = 4;
  localparam int PW = 2 * CW + 2;
  localparam int SW = PW + 2;
  localparam int MW = SW - 1;
  localparam int NW = 30;
  localparam int NORM_MSB = NW - 1;
  localparam int HW = $clog2(MW);
  localparam int QSW = 2 * NW;
  localparam int SUMW = QSW + 2;
  localparam int RW = SUMW / 2;
  localparam int DW = NW + FB + 1;
  localparam int QW = FB + 1;

  typedef logic [NC-1:0][CW-1:0] comp_vec_t;

  typedef struct packed {
    logic                   zero;
    logic [NC-1:0]          neg;
    logic [NC-1:0][NW-1:0]  q;
  } norm_t;

endpackage
`default_nettype wire

// ===== rtl/qmn_product.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_product
// Two-stage Hamilton product: sixteen partial products, then four sums.
// ----------------------------------------------------------------------------
module qmn_product
  import qmn_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  comp_vec_t                  a,
  input  comp_vec_t                  b,
  input  logic                       conj_b,
  output logic                       out_valid,
  output logic signed [NC-1:0][SW-1:0] p
);

  logic signed [PW-1:0] prod [NC*NC];
  logic signed [PW-1:0] prod_next [NC*NC];
  logic [1:0]           valid;

  always_comb begin
    logic signed [CW:0] ae;
    logic signed [CW:0] be;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        ae = $signed({a[i][CW-1], a[i]});
        be = $signed({b[j][CW-1], b[j]});
        if (conj_b && j > 0) begin
          be = -be;
        end
        prod_next[i*NC+j] = $signed({{(PW-CW-1){ae[CW]}}, ae}) *
                            $signed({{(PW-CW-1){be[CW]}}, be});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NC*NC; k++) begin
        prod[k] <= prod_next[k];
      end
      p[0] <= SW'(prod[0])  - SW'(prod[5])  - SW'(prod[10]) - SW'(prod[15]);
      p[1] <= SW'(prod[1])  + SW'(prod[4])  + SW'(prod[11]) - SW'(prod[14]);
      p[2] <= SW'(prod[2])  - SW'(prod[7])  + SW'(prod[8])  + SW'(prod[13]);
      p[3] <= SW'(prod[3])  + SW'(prod[6])  - SW'(prod[9])  + SW'(prod[12]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[0], in_valid};
    end
  end

  assign out_valid = valid[1];

endmodule
`default_nettype wire

// ===== rtl/qmn_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_scale
// Magnitudes, common block shift into the normalized range, squares and
// their sum, over five stages.
// ----------------------------------------------------------------------------
module qmn_scale
  import qmn_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [NC-1:0][SW-1:0] p,
  output logic                         out_valid,
  output logic [SUMW-1:0]              sum,
  output norm_t                        norm
);

  logic [4:0]            valid;
  logic [MW-1:0]         mag1 [NC];
  logic [NC-1:0]         neg1;
  logic [MW-1:0]         max1;
  logic [MW-1:0]         mag2 [NC];
  logic [NC-1:0]         neg2;
  logic [HW-1:0]         msb2;
  logic                  zero2;
  logic [NC-1:0][NW-1:0] q3;
  logic [NC-1:0]         neg3;
  logic                  zero3;
  logic [QSW-1:0]        sq4 [NC];
  norm_t                 norm4;

  logic [MW-1:0]         mag_next [NC];
  logic [MW-1:0]         max_next;
  logic [HW-1:0]         msb_next;
  logic [NC-1:0][NW-1:0] q_next;

  always_comb begin
    logic [MW-1:0] m01;
    logic [MW-1:0] m23;
    for (int i = 0; i < NC; i++) begin
      mag_next[i] = p[i][SW-1] ? MW'(-p[i]) : MW'(p[i]);
    end
    m01 = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
    m23 = (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
    max_next = (m01 > m23) ? m01 : m23;
  end

  always_comb begin
    msb_next = '0;
    for (int k = 0; k < MW; k++) begin
      if (max1[k]) begin
        msb_next = HW'(k);
      end
    end
  end

  always_comb begin
    logic [MW-1:0] t;
    for (int i = 0; i < NC; i++) begin
      if (msb2 >= HW'(NORM_MSB)) begin
        t = mag2[i] >> (msb2 - HW'(NORM_MSB));
      end else begin
        t = mag2[i] << (HW'(NORM_MSB) - msb2);
      end
      q_next[i] = t[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        mag1[i] <= mag_next[i];
        neg1[i] <= p[i][SW-1];
        mag2[i] <= mag1[i];
        sq4[i]  <= QSW'(q3[i]) * QSW'(q3[i]);
      end
      max1  <= max_next;
      neg2  <= neg1;
      msb2  <= msb_next;
      zero2 <= (max1 == '0);
      q3    <= q_next;
      neg3  <= neg2;
      zero3 <= zero2;
      norm4.q    <= q3;
      norm4.neg  <= neg3;
      norm4.zero <= zero3;
      sum  <= SUMW'(sq4[0]) + SUMW'(sq4[1]) + SUMW'(sq4[2]) + SUMW'(sq4[3]);
      norm <= norm4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  assign out_valid = valid[4];

endmodule
`default_nettype wire

// ===== rtl/qmn_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_sqrt
// Pipelined integer square root of the sum of squares, one root bit per
// stage.
// ----------------------------------------------------------------------------
module qmn_sqrt
  import qmn_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [SUMW-1:0] sum,
  input  norm_t           norm_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output norm_t           norm_out
);

  logic [RW-1:0]   valid;
  logic [SUMW-1:0] rem      [RW];
  logic [SUMW-1:0] res      [RW];
  norm_t           nrm      [RW];
  logic [SUMW-1:0] rem_next [RW];
  logic [SUMW-1:0] res_next [RW];

  always_comb begin
    logic [SUMW-1:0] src_rem [RW];
    logic [SUMW-1:0] src_res [RW];
    logic [SUMW-1:0] bitv;
    logic [SUMW:0]   trial;
    src_rem[0] = sum;
    src_res[0] = '0;
    for (int k = 1; k < RW; k++) begin
      src_rem[k] = rem[k-1];
      src_res[k] = res[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      bitv  = SUMW'(1) << (2 * (RW - 1 - k));
      trial = (SUMW+1)'(src_res[k]) + (SUMW+1)'(bitv);
      if ((SUMW+1)'(src_rem[k]) >= trial) begin
        rem_next[k] = src_rem[k] - SUMW'(trial);
        res_next[k] = (src_res[k] >> 1) + bitv;
      end else begin
        rem_next[k] = src_rem[k];
        res_next[k] = src_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm[0] <= norm_in;
      for (int k = 0; k < RW; k++) begin
        rem[k] <= rem_next[k];
        res[k] <= res_next[k];
      end
      for (int k = 1; k < RW; k++) begin
        nrm[k] <= nrm[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[RW-2:0], in_valid};
    end
  end

  assign out_valid = valid[RW-1];
  assign root      = res[RW-1][RW-1:0];
  assign norm_out  = nrm[RW-1];

endmodule
`default_nettype wire

// ===== rtl/qmn_divide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_divide
// Four-lane pipelined restoring division of the scaled magnitudes by the
// root with rounding, then sign and zero handling into the output register.
// ----------------------------------------------------------------------------
module qmn_divide
  import qmn_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] root,
  input  norm_t         norm,
  output logic          out_valid,
  output comp_vec_t     r,
  output logic          zero
);

  logic [QW+1:0]   valid;
  logic [DW-1:0]   num0 [NC];
  logic [RW-1:0]   den0;
  logic [NC-1:0]   neg0;
  logic            zero0;
  logic [DW-1:0]   rem  [QW][NC];
  logic [QW-1:0]   quo  [QW][NC];
  logic [RW-1:0]   den  [QW];
  logic [NC-1:0]   negs [QW];
  logic            zs   [QW];
  logic [DW-1:0]   rem_next [QW][NC];
  logic [QW-1:0]   quo_next [QW][NC];

  always_comb begin
    logic [DW-1:0] src_rem [QW][NC];
    logic [QW-1:0] src_quo [QW][NC];
    logic [RW-1:0] src_den [QW];
    logic [DW-1:0] trial;
    src_den[0] = den0;
    for (int i = 0; i < NC; i++) begin
      src_rem[0][i] = num0[i];
      src_quo[0][i] = '0;
    end
    for (int k = 1; k < QW; k++) begin
      src_den[k] = den[k-1];
      for (int i = 0; i < NC; i++) begin
        src_rem[k][i] = rem[k-1][i];
        src_quo[k][i] = quo[k-1][i];
      end
    end
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < NC; i++) begin
        trial = DW'(src_den[k]) << (QW - 1 - k);
        if (src_rem[k][i] >= trial) begin
          rem_next[k][i] = src_rem[k][i] - trial;
          quo_next[k][i] = src_quo[k][i] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_next[k][i] = src_rem[k][i];
          quo_next[k][i] = src_quo[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [CW-1:0] mag;
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        num0[i] <= (DW'(norm.q[i]) << FB) + DW'(root >> 1);
      end
      den0  <= root;
      neg0  <= norm.neg;
      zero0 <= norm.zero;
      for (int k = 0; k < QW; k++) begin
        for (int i = 0; i < NC; i++) begin
          rem[k][i] <= rem_next[k][i];
          quo[k][i] <= quo_next[k][i];
        end
      end
      den[0]  <= den0;
      negs[0] <= neg0;
      zs[0]   <= zero0;
      for (int k = 1; k < QW; k++) begin
        den[k]  <= den[k-1];
        negs[k] <= negs[k-1];
        zs[k]   <= zs[k-1];
      end
      for (int i = 0; i < NC; i++) begin
        mag = CW'(quo[QW-1][i]);
        if (zs[QW-1]) begin
          r[i] <= '0;
        end else if (negs[QW-1][i]) begin
          r[i] <= -mag;
        end else begin
          r[i] <= mag;
        end
      end
      zero <= zs[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[QW:0], in_valid};
    end
  end

  assign out_valid = valid[QW+1];

endmodule
`default_nettype wire

// ===== rtl/quaternion_multiply_normalize_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_core
// Normalized Hamilton product of two Q2.14 quaternions.
//
// The input channel (in_valid, in_stall) carries one item: quaternions a and
// b and a flag that conjugates b. The output channel (out_valid, out_stall)
// returns the unit product r in Q2.14 and a flag for a zero product, whose
// components are then zero.
// One item is accepted every cycle unless the output stalls. An item passes
// through the product, then magnitudes, block shift and sum of squares, then
// the square root at one root bit per stage, and the division at one
// quotient bit per stage plus setup and output.
// Reset clears all stage valid bits; no item is in flight afterwards.
// While the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_core
  import qmn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] a_w,
  input  logic signed [CW-1:0] a_x,
  input  logic signed [CW-1:0] a_y,
  input  logic signed [CW-1:0] a_z,
  input  logic signed [CW-1:0] b_w,
  input  logic signed [CW-1:0] b_x,
  input  logic signed [CW-1:0] b_y,
  input  logic signed [CW-1:0] b_z,
  input  logic                 conj_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] r_w,
  output logic signed [CW-1:0] r_x,
  output logic signed [CW-1:0] r_y,
  output logic signed [CW-1:0] r_z,
  output logic                 zero_norm
);

  logic                         en;
  comp_vec_t                    a;
  comp_vec_t                    b;
  logic                         prod_valid;
  logic signed [NC-1:0][SW-1:0] p;
  logic                         scale_valid;
  logic [SUMW-1:0]              sum;
  norm_t                        scale_norm;
  logic                         sqrt_valid;
  logic [RW-1:0]                root;
  norm_t                        sqrt_norm;
  comp_vec_t                    r;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign a = {a_z, a_y, a_x, a_w};
  assign b = {b_z, b_y, b_x, b_w};

  qmn_product u_product (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a         (a),
    .b         (b),
    .conj_b    (conj_b),
    .out_valid (prod_valid),
    .p         (p)
  );

  qmn_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prod_valid),
    .p         (p),
    .out_valid (scale_valid),
    .sum       (sum),
    .norm      (scale_norm)
  );

  qmn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (scale_valid),
    .sum       (sum),
    .norm_in   (scale_norm),
    .out_valid (sqrt_valid),
    .root      (root),
    .norm_out  (sqrt_norm)
  );

  qmn_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .root      (root),
    .norm      (sqrt_norm),
    .out_valid (out_valid),
    .r         (r),
    .zero      (zero_norm)
  );

  assign r_w = $signed(r[0]);
  assign r_x = $signed(r[1]);
  assign r_y = $signed(r[2]);
  assign r_z = $signed(r[3]);

endmodule
`default_nettype wire

// ===== test/qmn_checker.sv =====
// ----------------------------------------------------------------------------
// qmn_checker
// Watches both channels of the normalized quaternion product, computes the
// expected unit product for every accepted item and compares each accepted
// result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module qmn_checker
  import qmn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CW-1:0] a_w,
  input  logic signed [CW-1:0] a_x,
  input  logic signed [CW-1:0] a_y,
  input  logic signed [CW-1:0] a_z,
  input  logic signed [CW-1:0] b_w,
  input  logic signed [CW-1:0] b_x,
  input  logic signed [CW-1:0] b_y,
  input  logic signed [CW-1:0] b_z,
  input  logic                 conj_b,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [CW-1:0] r_w,
  input  logic signed [CW-1:0] r_x,
  input  logic signed [CW-1:0] r_y,
  input  logic signed [CW-1:0] r_z,
  input  logic                 zero_norm,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [NC-1:0][CW-1:0] comp;
    logic                  zero;
  } unit_prod_t;

  unit_prod_t expected_products[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic unit_prod_t unit_product(
    longint aw, longint ax, longint ay, longint az,
    longint bw, longint bx, longint by, longint bz, logic cj);
    unit_prod_t res;
    longint p [4];
    longint unsigned mag [4];
    longint unsigned m;
    longint unsigned sum;
    longint unsigned s;
    longint unsigned quo;
    longint v;
    int rsh;
    int lsh;
    res = '0;
    m = 0;
    sum = 0;
    rsh = 0;
    lsh = 0;
    if (cj) begin
      bx = -bx;
      by = -by;
      bz = -bz;
    end
    p[0] = aw * bw - ax * bx - ay * by - az * bz;
    p[1] = aw * bx + ax * bw + ay * bz - az * by;
    p[2] = aw * by - ax * bz + ay * bw + az * bx;
    p[3] = aw * bz + ax * by - ay * bx + az * bw;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      res.zero = 1'b1;
      return res;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      rsh++;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      lsh++;
    end
    for (int i = 0; i < 4; i++) begin
      mag[i] = (mag[i] >> rsh) << lsh;
      sum += mag[i] * mag[i];
    end
    s = root_floor(sum);
    for (int i = 0; i < 4; i++) begin
      quo = ((mag[i] << FB) + (s >> 1)) / s;
      if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
      v = (p[i] < 0) ? -longint'(quo) : longint'(quo);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res.comp[i] = v[CW-1:0];
    end
    return res;
  endfunction

  assign pending = expected_products.size();

  always @(posedge clk) begin
    unit_prod_t want;
    unit_prod_t got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_products.push_back(unit_product(a_w, a_x, a_y, a_z,
                                                 b_w, b_x, b_y, b_z, conj_b));
      end
      if (out_valid && !out_stall) begin
        got.comp = {r_z, r_y, r_x, r_w};
        got.zero = zero_norm;
        if (expected_products.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result item: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_products.pop_front();
          if (want != got) begin
            if (fail_count < 10) begin
              $display("Mismatch: expected w=%0d x=%0d y=%0d z=%0d zero=%0b",
                       $signed(want.comp[0]), $signed(want.comp[1]),
                       $signed(want.comp[2]), $signed(want.comp[3]), want.zero);
              $display("          actual   w=%0d x=%0d y=%0d z=%0d zero=%0b",
                       r_w, r_x, r_y, r_z, zero_norm);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the normalized quaternion product: directed corner items,
// then random quaternions under three idling patterns and one long output
// hold-off. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import qmn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
  logic signed [CW-1:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
  logic conj_b = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] r_w, r_x, r_y, r_z;
  logic zero_norm;
  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int quiet_cycles = 0;
  logic [15:0] corner [6] = '{16'h0000, 16'h0001, 16'h4000, 16'hC000, 16'h7FFF,
                              16'h8000};

  always #4 clk = ~clk;

  quaternion_multiply_normalize_core DUT (.*);

  qmn_checker checker_i (.*);

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cycles <= 200;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && (in_valid && !in_stall || out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_item(logic [15:0] aw, ax, ay, az, bw, bx, by, bz, logic cj);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    a_w <= aw; a_x <= ax; a_y <= ay; a_z <= az;
    b_w <= bw; b_x <= bx; b_y <= by; b_z <= bz;
    conj_b <= cj;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    logic [15:0] v [8];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 8; i++) begin
      if (kind == 0) v[i] = corner[3'($urandom_range(5))];
      else if (kind == 1) v[i] = 16'($urandom_range(7) - 3);
      else if (kind == 2) v[i] = (i == 0 || i == 4) ? 16'($urandom()) : 16'h0000;
      else v[i] = 16'($urandom());
    end
    send_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7],
              1'($urandom_range(1)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 0);
    send_item(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 1);
    send_item(0, 16'h4000, 0, 0, 0, 0, 0, 0, 0);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_item(16'h8000, 0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 1);
    send_item(1, 0, 0, 0, 1, 0, 0, 0, 0);
    send_item(0, 0, 0, 1, 0, 0, 1, 0, 1);
    send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1, 1);
    send_item(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
              16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 0);
    send_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
              16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1);
    send_item(16'h2D41, 16'h2D41, 0, 0, 16'h2D41, 0, 16'h2D41, 0, 0);
    send_item(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
              16'h4000, 16'h4000, 1);
    send_idle_pct = 27;
    recv_idle_pct = 48;
    repeat (260) send_random();
    hold_req <= 1'b1;
    repeat (100) send_random();
    send_idle_pct = 48;
    recv_idle_pct = 27;
    repeat (220) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (220) send_random();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qmn_pkg.sv
rtl/qmn_product.sv
rtl/qmn_scale.sv
rtl/qmn_sqrt.sv
rtl/qmn_divide.sv
rtl/quaternion_multiply_normalize_core.sv
test/qmn_checker.sv
test/testbench.sv
